### hw/rtl/itf_pkg.sv
// types, constants and helpers shared by the integer text formatter
// no dependencies
package itf_pkg;

  localparam int VALUE_BITS    = 64;
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_PRECISION = 63;

  // digit register is sized for octal, the radix with the most digits
  localparam int DIGITS    = (VALUE_BITS + 2) / 3;
  localparam int DIG_BITS  = DIGITS * 4;
  localparam int ND_W      = $clog2(DIGITS + 1);
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_LOW_A = 7'h61;
  localparam logic [6:0] CH_UP_A  = 7'h41;

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic [1:0]  radix_sel;
    logic        upper_case;
    logic [6:0]  field_width;
    logic        has_precision;
    logic [5:0]  min_digits;
    logic        left_align;
    logic        force_plus;
    logic        space_sign;
    logic        zero_pad;
  } in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       start;
    logic       pop;
    logic [1:0] radix;
  } conv_ctrl_t;

  typedef struct packed {
    logic            done;
    logic [ND_W-1:0] nd;
    logic [3:0]      digit;
  } conv_stat_t;

  typedef enum logic [1:0] {
    C_DONE,
    C_CONV,
    C_NORM
  } conv_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_WAIT,
    T_SETUP_A,
    T_SETUP_B,
    T_EMIT
  } top_state_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (d < 4'd10) begin
      return CH_ZERO + 7'(d);
    end else begin
      return base + 7'(d - 4'd10);
    end
  endfunction

endpackage

### hw/rtl/integer_to_text_formatter_unit.sv
// integer text formatter top level: field layout and character output
// uses itf_pkg and itf_digit_conv
// sequence: the converter runs the bcd shift loop (decimal only) and leading zero removal,
//   then T_SETUP_A and T_SETUP_B, then one character per cycle while the output is not stalled
// one item at a time, the next taken once the last character is loaded
//   into the output register; the bcd shift loop, the field length and output stalls set the rate
// reset clears the sequencer, the converter state and the output valid
module integer_to_text_formatter_unit import itf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  top_state_t state, state_next;
  conv_ctrl_t ctrl;
  conv_stat_t stat;

  logic [VALUE_BITS-1:0] val_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  neg_in;
  logic                  skip_in;
  logic                  accept;
  logic                  load;
  logic                  is_digit;

  logic             upper;
  logic             left;
  logic             zpad;
  logic             has_prec;
  logic [CNT_W-1:0] prec;
  logic [CNT_W-1:0] wid;
  logic             sign_w;
  logic [6:0]       sign_ch;
  logic [CNT_W-1:0] zeros;
  logic [CNT_W-1:0] core;
  logic [CNT_W-1:0] b1, b2, b3, b4, tot;
  logic [CNT_W-1:0] pos;

  logic [CNT_W-1:0] nd_c;
  logic             use_prec;
  logic [CNT_W-1:0] fill;
  logic             zfill;
  logic [CNT_W-1:0] lsp;
  logic [CNT_W-1:0] zeros2;
  logic [6:0]       ch;

  itf_digit_conv u_conv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .mag  (mag_in),
    .stat (stat)
  );

  assign val_in  = in_data.value[VALUE_BITS-1:0];
  assign neg_in  = in_data.is_signed && val_in[VALUE_BITS-1];
  assign mag_in  = neg_in ? (~val_in + VALUE_BITS'(1)) : val_in;
  assign skip_in = in_data.has_precision && (in_data.min_digits == 6'd0) && (val_in == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load       = 1'b0;
    ctrl.start = 1'b0;
    ctrl.radix = in_data.radix_sel;
    case (state)
      T_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !skip_in) begin
          ctrl.start = 1'b1;
          state_next = T_WAIT;
        end
      end
      T_WAIT: begin
        if (stat.done) begin
          state_next = T_SETUP_A;
        end
      end
      T_SETUP_A: state_next = T_SETUP_B;
      T_SETUP_B: state_next = T_EMIT;
      T_EMIT: begin
        load = !out_valid || out_ready;
        if (load && pos == tot - CNT_W'(1)) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
    ctrl.pop = load && is_digit;
  end

  assign accept    = in_valid && in_ready;
  assign is_digit  = (pos >= b3) && (pos < b4);

  // field layout
  assign nd_c     = CNT_W'(stat.nd);
  assign use_prec = has_prec && (prec > nd_c);
  assign fill     = (wid > core) ? wid - core : '0;
  assign zfill    = zpad && !has_prec && !left;
  assign lsp      = (!left && !zfill) ? fill : '0;
  assign zeros2   = zeros + (zfill ? fill : CNT_W'(0));

  always_comb begin
    if (pos < b1) begin
      ch = CH_SPACE;
    end else if (pos < b2) begin
      ch = sign_ch;
    end else if (pos < b3) begin
      ch = CH_ZERO;
    end else if (pos < b4) begin
      ch = digit_char(stat.digit, upper);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upper    <= in_data.upper_case;
      left     <= in_data.left_align;
      zpad     <= in_data.zero_pad;
      has_prec <= in_data.has_precision;
      prec     <= (CNT_W'(in_data.min_digits) > CNT_W'(MAX_PRECISION)) ?
                  CNT_W'(MAX_PRECISION) : CNT_W'(in_data.min_digits);
      wid      <= (CNT_W'(in_data.field_width) > CNT_W'(MAX_WIDTH)) ?
                  CNT_W'(MAX_WIDTH) : CNT_W'(in_data.field_width);
      sign_w   <= in_data.is_signed &&
                  (neg_in || in_data.force_plus || in_data.space_sign);
      sign_ch  <= neg_in ? CH_MINUS : (in_data.force_plus ? CH_PLUS : CH_SPACE);
    end
    if (state == T_SETUP_A) begin
      zeros <= use_prec ? prec - nd_c : '0;
      core  <= CNT_W'(sign_w) + (use_prec ? prec : nd_c);
    end
    if (state == T_SETUP_B) begin
      b1  <= lsp;
      b2  <= lsp + CNT_W'(sign_w);
      b3  <= lsp + CNT_W'(sign_w) + zeros2;
      b4  <= lsp + CNT_W'(sign_w) + zeros2 + nd_c;
      tot <= core + fill;
      pos <= '0;
    end else if (load) begin
      pos <= pos + CNT_W'(1);
    end
    if (load) begin
      out_data.char_code <= ch;
      out_data.last      <= (pos == tot - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/itf_digit_conv.sv
// digit converter: bit-serial binary to bcd, octal and hex digit split,
// leading zero removal one digit per cycle; uses itf_pkg
module itf_digit_conv import itf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  conv_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] mag,
  output conv_stat_t            stat
);

  conv_state_t           state, state_next;
  logic [DIG_BITS-1:0]   dig;
  logic [VALUE_BITS-1:0] sh;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [ND_W-1:0]       nd;

  logic [DIG_BITS-1:0] magx;
  logic [DIG_BITS-1:0] load_dig;
  logic [DIG_BITS-1:0] adj;
  logic [3:0]          top_dig;

  assign magx    = DIG_BITS'(mag);
  assign top_dig = dig[DIG_BITS-1 -: 4];

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (ctrl.radix == RADIX_OCT) begin
        load_dig[4*i +: 4] = {1'b0, magx[3*i +: 3]};
      end else begin
        load_dig[4*i +: 4] = magx[4*i +: 4];
      end
      // add three before each shift so a digit never passes nine
      adj[4*i +: 4] = (dig[4*i +: 4] >= 4'd5) ? dig[4*i +: 4] + 4'd3 : dig[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_DONE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      C_DONE: begin
        if (ctrl.start) begin
          state_next = (ctrl.radix == RADIX_DEC) ? C_CONV : C_NORM;
        end
      end
      C_CONV: begin
        if (bit_cnt == '0) begin
          state_next = C_NORM;
        end
      end
      C_NORM: begin
        if (top_dig != 4'd0 || nd == ND_W'(1)) begin
          state_next = C_DONE;
        end
      end
      default: state_next = C_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      C_DONE: begin
        if (ctrl.start) begin
          nd      <= ND_W'(DIGITS);
          sh      <= mag;
          bit_cnt <= BIT_CNT_W'(VALUE_BITS - 1);
          dig     <= (ctrl.radix == RADIX_DEC) ? '0 : load_dig;
        end else if (ctrl.pop) begin
          dig <= {dig[DIG_BITS-5:0], 4'd0};
        end
      end
      C_CONV: begin
        dig     <= {adj[DIG_BITS-2:0], sh[VALUE_BITS-1]};
        sh      <= {sh[VALUE_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt - BIT_CNT_W'(1);
      end
      C_NORM: begin
        if (top_dig == 4'd0 && nd != ND_W'(1)) begin
          dig <= {dig[DIG_BITS-5:0], 4'd0};
          nd  <= nd - ND_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign stat.done  = (state == C_DONE);
  assign stat.nd    = nd;
  assign stat.digit = top_dig;

endmodule
